// ===== rtl/core/pfo_pkg.sv =====
// types, constants and helper functions for the plane frame block
// used by every module in rtl/core; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package pfo_pkg;

  // 0.9 in q2.30
  localparam logic [31:0] SeedLimit = 32'd966367641;

  localparam logic [1:0] KindAxisU  = 2'd0;
  localparam logic [1:0] KindAxisV  = 2'd1;
  localparam logic [1:0] KindNormal = 2'd2;
  localparam logic [1:0] KindCentre = 2'd3;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [30:0]        reach;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic               last;
    logic               degenerate;
  } out_item_t;

  typedef struct packed {
    logic [2:0][29:0] m;
    logic             zero;
  } norm_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [2:0][29:0] m;
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][31:0] point;
    logic [30:0]      reach;
  } work_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

  // shift all three so the largest lands in [2^29, 2^30)
  function automatic norm_t norm3(input logic [2:0][31:0] mag);
    norm_t       r;
    logic [31:0] mx;
    logic [4:0]  p;
    logic [31:0] t;
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mx[i]) p = 5'(i);
    end
    r.zero = (mx == 32'd0);
    for (int j = 0; j < 3; j++) begin
      if (p >= 5'd29) t = mag[j] >> (p - 5'd29);
      else t = mag[j] << (5'd29 - p);
      r.m[j] = t[29:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pfo_front.sv =====
// front stage: accepts a plane, takes magnitudes and normalizes the normal
// depends on pfo_pkg
`timescale 1ns / 1ps
`default_nettype none
module pfo_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire pfo_pkg::in_item_t in_data_i,
  output logic                  wk_valid_o,
  input  wire logic             wk_ready_i,
  output pfo_pkg::work_t        wk_data_o
);

  logic           valid_q, valid_d;
  pfo_pkg::work_t data_q, data_d;
  pfo_pkg::norm_t nrm;
  logic [2:0][31:0] mag;

  assign in_ready_o = !valid_q || wk_ready_i;

  always_comb begin
    mag[0] = pfo_pkg::mag32(in_data_i.normal_x);
    mag[1] = pfo_pkg::mag32(in_data_i.normal_y);
    mag[2] = pfo_pkg::mag32(in_data_i.normal_z);
    nrm    = pfo_pkg::norm3(mag);
    data_d.m     = nrm.m;
    data_d.zero  = nrm.zero;
    data_d.neg   = {in_data_i.normal_z[31], in_data_i.normal_y[31], in_data_i.normal_x[31]};
    data_d.point = {in_data_i.point_z, in_data_i.point_y, in_data_i.point_x};
    data_d.reach = in_data_i.reach;
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) valid_d = 1'b1;
    else if (wk_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) data_q <= data_d;
  end

  assign wk_valid_o = valid_q;
  assign wk_data_o  = data_q;

endmodule
`default_nettype wire

// ===== rtl/core/pfo_queue.sv =====
// two-entry queue between front and back
// depends on pfo_pkg
`timescale 1ns / 1ps
`default_nettype none
module pfo_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire pfo_pkg::work_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output pfo_pkg::work_t      pop_data_o
);

  pfo_pkg::work_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// ===== rtl/core/pfo_back.sv =====
// back stage: square root, division and multiply sequencer plus result emitter
// depends on pfo_pkg
`timescale 1ns / 1ps
`default_nettype none
module pfo_back #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wk_valid_i,
  output logic                wk_ready_o,
  input  wire pfo_pkg::work_t wk_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output pfo_pkg::out_item_t  out_data_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSumSq = 3'd1;
  localparam logic [2:0] StSqrt  = 3'd2;
  localparam logic [2:0] StDInit = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StPrep  = 3'd5;
  localparam logic [2:0] StMul   = 3'd6;
  localparam logic [2:0] StFin   = 3'd7;

  localparam logic signed [64:0] SatHi = (65'sd1 <<< (COORD_WIDTH - 1)) - 65'sd1;
  localparam logic signed [64:0] SatLo = -SatHi - 65'sd1;

  logic [2:0]       st_q;
  logic             ph_q;
  logic [4:0]       k_q;
  logic [1:0]       ci_q;
  logic [2:0][29:0] m_q;
  logic [2:0]       neg_q;
  logic [61:0]      acc_q;
  logic [61:0]      ssrc_q;
  logic [34:0]      srem_q;
  logic [30:0]      sres_q;
  logic [30:0]      drem_q;
  logic [31:0]      dlow_q;
  logic [31:0]      qq_q;
  logic [2:0][31:0] pt_q;
  logic [30:0]      reach_q;
  logic [2:0][31:0] nn_q, u_q, v_q, ctr_q;
  logic             deg_q, sat_q;
  logic signed [63:0] prod_q, tmp_q;

  // emitter copy
  logic             ob_valid_q;
  logic [1:0]       beat_q;
  logic [2:0][31:0] e_u_q, e_v_q, e_nn_q, e_ctr_q;
  logic             e_deg_q, e_sat_q;

  // combinational helpers
  logic [59:0]      sq;
  logic [34:0]      rem_sh, trial;
  logic [60:0]      dnum;
  logic [31:0]      dt;
  logic             qbit;
  logic [31:0]      qn, qs;
  logic signed [31:0] opa, opb;
  logic [3:0]       j;
  logic [1:0]       ix;
  logic signed [63:0] diff, rv, cc;
  logic signed [64:0] cx;
  logic [2:0][31:0] av, amag;
  pfo_pkg::norm_t   anrm;
  logic             sel_y;

  function automatic logic signed [63:0] rnd30(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = (x + 64'sd536870912) >>> 30;
    return t;
  endfunction

  assign wk_ready_o = (st_q == StIdle);

  always_comb begin
    sq     = 60'(m_q[k_q[1:0]]) * 60'(m_q[k_q[1:0]]);
    rem_sh = {srem_q[32:0], ssrc_q[61:60]};
    trial  = {2'b00, sres_q, 2'b01};
    dnum   = {1'b0, m_q[ci_q], 30'd0} + 61'(sres_q >> 1);
    dt     = {drem_q, dlow_q[31]};
    qbit   = (dt >= {1'b0, sres_q});
    qn     = {qq_q[30:0], qbit};
    qs     = neg_q[ci_q] ? (~qn + 32'd1) : qn;
    case (k_q[3:0])
      4'd0:    begin opa = $signed(nn_q[1]); opb = $signed(u_q[2]); end
      4'd1:    begin opa = $signed(nn_q[2]); opb = $signed(u_q[1]); end
      4'd2:    begin opa = $signed(nn_q[2]); opb = $signed(u_q[0]); end
      4'd3:    begin opa = $signed(nn_q[0]); opb = $signed(u_q[2]); end
      4'd4:    begin opa = $signed(nn_q[0]); opb = $signed(u_q[1]); end
      4'd5:    begin opa = $signed(nn_q[1]); opb = $signed(u_q[0]); end
      4'd6:    begin opa = $signed({1'b0, reach_q}); opb = $signed(nn_q[0]); end
      4'd7:    begin opa = $signed({1'b0, reach_q}); opb = $signed(nn_q[1]); end
      4'd8:    begin opa = $signed({1'b0, reach_q}); opb = $signed(nn_q[2]); end
      default: begin opa = '0; opb = '0; end
    endcase
    j    = k_q[3:0] - 4'd1;
    // centre component for j = 6, 7, 8
    ix   = j[1:0] + 2'd2;
    diff = tmp_q - prod_q;
    rv   = rnd30(diff);
    cc   = $signed({{32{pt_q[ix][31]}}, pt_q[ix]}) - rnd30(prod_q);
    cx   = {cc[63], cc};
    // seed axis choice
    sel_y = (pfo_pkg::mag32(nn_q[0]) > pfo_pkg::SeedLimit);
    if (sel_y) begin
      av[0] = nn_q[2]; av[1] = 32'd0; av[2] = ~nn_q[0] + 32'd1;
    end else begin
      av[0] = 32'd0; av[1] = ~nn_q[2] + 32'd1; av[2] = nn_q[1];
    end
    for (int i = 0; i < 3; i++) amag[i] = pfo_pkg::mag32(av[i]);
    anrm = pfo_pkg::norm3(amag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StIdle;
      ob_valid_q <= 1'b0;
      beat_q     <= 2'd0;
      ph_q       <= 1'b0;
      k_q        <= 5'd0;
      ci_q       <= 2'd0;
    end else begin
      if (ob_valid_q && out_ready_i) begin
        if (beat_q == pfo_pkg::KindCentre) ob_valid_q <= 1'b0;
        beat_q <= beat_q + 2'd1;
      end
      case (st_q)
        StIdle: begin
          if (wk_valid_i) begin
            m_q     <= wk_data_i.m;
            neg_q   <= wk_data_i.neg;
            pt_q    <= wk_data_i.point;
            reach_q <= wk_data_i.reach;
            deg_q   <= wk_data_i.zero;
            sat_q   <= 1'b0;
            acc_q   <= '0;
            k_q     <= 5'd0;
            ph_q    <= 1'b0;
            if (wk_data_i.zero) begin
              nn_q  <= '0;
              u_q   <= '0;
              v_q   <= '0;
              ctr_q <= '0;
              st_q  <= StFin;
            end else begin
              st_q <= StSumSq;
            end
          end
        end
        StSumSq: begin
          acc_q <= acc_q + {2'b00, sq};
          k_q   <= k_q + 5'd1;
          if (k_q == 5'd2) begin
            ssrc_q <= acc_q + {2'b00, sq};
            srem_q <= '0;
            sres_q <= '0;
            k_q    <= 5'd0;
            st_q   <= StSqrt;
          end
        end
        StSqrt: begin
          if (rem_sh >= trial) begin
            srem_q <= rem_sh - trial;
            sres_q <= {sres_q[29:0], 1'b1};
          end else begin
            srem_q <= rem_sh;
            sres_q <= {sres_q[29:0], 1'b0};
          end
          ssrc_q <= {ssrc_q[59:0], 2'b00};
          k_q    <= k_q + 5'd1;
          if (k_q == 5'd30) begin
            ci_q <= 2'd0;
            st_q <= StDInit;
          end
        end
        StDInit: begin
          drem_q <= {2'b00, dnum[60:32]};
          dlow_q <= dnum[31:0];
          qq_q   <= '0;
          k_q    <= 5'd0;
          st_q   <= StDiv;
        end
        StDiv: begin
          drem_q <= qbit ? 31'(dt - {1'b0, sres_q}) : dt[30:0];
          dlow_q <= {dlow_q[30:0], 1'b0};
          qq_q   <= qn;
          k_q    <= k_q + 5'd1;
          if (k_q == 5'd31) begin
            if (ph_q) u_q[ci_q] <= qs;
            else nn_q[ci_q] <= qs;
            ci_q <= ci_q + 2'd1;
            if (ci_q == 2'd2) begin
              k_q  <= 5'd0;
              st_q <= ph_q ? StMul : StPrep;
            end else begin
              st_q <= StDInit;
            end
          end
        end
        StPrep: begin
          m_q   <= anrm.m;
          neg_q <= {av[2][31], av[1][31], av[0][31]};
          ph_q  <= 1'b1;
          acc_q <= '0;
          k_q   <= 5'd0;
          if (anrm.zero) begin
            u_q  <= '0;
            st_q <= StMul;
          end else begin
            st_q <= StSumSq;
          end
        end
        StMul: begin
          prod_q <= opa * opb;
          k_q    <= k_q + 5'd1;
          if (k_q != 5'd0) begin
            if (j < 4'd6) begin
              if (!j[0]) tmp_q <= prod_q;
              else v_q[j[2:1]] <= rv[31:0];
            end else begin
              if (cx > SatHi) begin
                ctr_q[ix] <= SatHi[31:0];
                sat_q <= 1'b1;
              end else if (cx < SatLo) begin
                ctr_q[ix] <= SatLo[31:0];
                sat_q <= 1'b1;
              end else begin
                ctr_q[ix] <= cc[31:0];
              end
            end
          end
          if (k_q == 5'd9) st_q <= StFin;
        end
        StFin: begin
          if (!ob_valid_q) begin
            e_u_q      <= u_q;
            e_v_q      <= v_q;
            e_nn_q     <= nn_q;
            e_ctr_q    <= ctr_q;
            e_deg_q    <= deg_q;
            e_sat_q    <= sat_q;
            ob_valid_q <= 1'b1;
            beat_q     <= 2'd0;
            st_q       <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    logic [2:0][31:0] c;
    case (beat_q)
      pfo_pkg::KindAxisU:  c = e_u_q;
      pfo_pkg::KindAxisV:  c = e_v_q;
      pfo_pkg::KindNormal: c = e_nn_q;
      default:             c = e_ctr_q;
    endcase
    out_data_o.result_kind = beat_q;
    out_data_o.comp_x      = c[0];
    out_data_o.comp_y      = c[1];
    out_data_o.comp_z      = c[2];
    out_data_o.last        = (beat_q == pfo_pkg::KindCentre);
    out_data_o.degenerate  = e_deg_q || ((beat_q == pfo_pkg::KindCentre) && e_sat_q);
  end

  assign out_valid_o = ob_valid_q;

  // a zero-normal plane gives zero components on the three vector beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate && !out_data_o.last)
      |-> (out_data_o.comp_x == 32'd0 && out_data_o.comp_y == 32'd0
           && out_data_o.comp_z == 32'd0))
    else $error("degenerate vector beat with nonzero component");

  // the four beats of a plane go out without a gap in valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_data_o.last) |=> out_valid_o)
    else $error("result beats of one plane interrupted");

  // the emitter is only reloaded when it is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StFin && ob_valid_q) |=> (st_q == StFin || $past(out_data_o.last)))
    else $error("sequencer left finish while emitter busy");

endmodule
`default_nettype wire

// ===== rtl/core/plane_frame_and_offset.sv =====
// top level of the plane frame and cube centre block
// depends on pfo_pkg, pfo_front, pfo_queue, pfo_back
//
// usage:
//   in channel (in_valid_i / in_ready_o / in_data_i) takes one plane per
//   transaction: point, unnormalized normal and reach, all q16.16.
//   out channel (out_valid_o / out_ready_i / out_data_o) gives four
//   transactions per plane: first axis, second axis, unit normal (q2.30),
//   then the cube centre (q16.16, saturated to COORD_WIDTH bits, last set).
//   a front register and a two-entry queue take new planes while the back
//   sequencer works, so up to five planes are in flight (front, queue,
//   sequencer and result emitter).
//   throughput is set by the back sequencer, which per plane runs two bit-serial
//   square roots, six restoring divisions and ten shared multiplier steps and
//   takes no new plane until it has handed its results to the emitter.
//   a zero normal skips the arithmetic and goes from idle straight to finish.
//   when the receiver stalls the result beat holds; the sequencer finishes
//   the next plane and waits, then the queue and front fill and in_ready_o
//   drops.
//   reset (rst_ni low, asynchronous) empties every stage; nothing else to clear.
`timescale 1ns / 1ps
`default_nettype none
module plane_frame_and_offset #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pfo_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output pfo_pkg::out_item_t      out_data_o
);

  logic           f_valid, f_ready, q_valid, q_ready;
  pfo_pkg::work_t f_data, q_data;

  pfo_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .wk_valid_o (f_valid),
    .wk_ready_i (f_ready),
    .wk_data_o  (f_data)
  );

  pfo_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  pfo_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wk_valid_i  (q_valid),
    .wk_ready_o  (q_ready),
    .wk_data_i   (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== bench/tb_plane_frame_and_offset.sv =====
// self-checking bench for plane_frame_and_offset: random and corner-case planes
// depends on pfo_pkg and the rtl/core modules; predicts all four results per plane
`timescale 1ns / 1ps
module tb_plane_frame_and_offset;

  localparam int HoldCycles = 3000;

  class frame_scoreboard;
    pfo_pkg::out_item_t expected_frames[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    task report_mismatch(input string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function longint unsigned isqrt(input longint unsigned s_in);
      longint unsigned s, res, b;
      s   = s_in;
      res = 0;
      b   = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= res + b) begin
          s   = s - (res + b);
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // unit vector in q2.30, zero flag returned as 0
    function bit unit3(input longint c[3], output longint o[3]);
      longint unsigned m[3], mx, s, r, q;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
        if (m[i] > mx) mx = m[i];
        o[i] = 0;
      end
      if (mx == 0) return 0;
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      r = isqrt(s);
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << 30) + (r >> 1)) / r;
        o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function longint rnd30(input longint x);
      return (x + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function void push(input logic [1:0] k, input longint c[3], input logic lst,
                       input logic deg);
      pfo_pkg::out_item_t e;
      e.result_kind = k;
      e.comp_x      = c[0][31:0];
      e.comp_y      = c[1][31:0];
      e.comp_z      = c[2][31:0];
      e.last        = lst;
      e.degenerate  = deg;
      expected_frames = {expected_frames, e};
    endfunction

    function void note_plane(input pfo_pkg::in_item_t it);
      longint p[3], n[3], nn[3], a[3], u[3], v[3], ctr[3], z[3], rch, cc, anx;
      logic   sat;
      bit     ok;
      p[0] = longint'(it.point_x);
      p[1] = longint'(it.point_y);
      p[2] = longint'(it.point_z);
      n[0] = longint'(it.normal_x);
      n[1] = longint'(it.normal_y);
      n[2] = longint'(it.normal_z);
      rch  = longint'({33'd0, it.reach});
      z    = '{0, 0, 0};
      ok   = unit3(n, nn);
      if (!ok) begin
        push(pfo_pkg::KindAxisU, z, 1'b0, 1'b1);
        push(pfo_pkg::KindAxisV, z, 1'b0, 1'b1);
        push(pfo_pkg::KindNormal, z, 1'b0, 1'b1);
        push(pfo_pkg::KindCentre, z, 1'b1, 1'b1);
        return;
      end
      anx = (nn[0] < 0) ? -nn[0] : nn[0];
      if (anx > longint'({32'd0, pfo_pkg::SeedLimit})) a = '{nn[2], 0, -nn[0]};
      else a = '{0, -nn[2], nn[1]};
      ok   = unit3(a, u);
      v[0] = rnd30(nn[1] * u[2] - nn[2] * u[1]);
      v[1] = rnd30(nn[2] * u[0] - nn[0] * u[2]);
      v[2] = rnd30(nn[0] * u[1] - nn[1] * u[0]);
      sat  = 1'b0;
      for (int i = 0; i < 3; i++) begin
        cc = p[i] - rnd30(rch * nn[i]);
        if (cc > 64'sd2147483647) begin
          cc  = 64'sd2147483647;
          sat = 1'b1;
        end else if (cc < -64'sd2147483648) begin
          cc  = -64'sd2147483648;
          sat = 1'b1;
        end
        ctr[i] = cc;
      end
      push(pfo_pkg::KindAxisU, u, 1'b0, 1'b0);
      push(pfo_pkg::KindAxisV, v, 1'b0, 1'b0);
      push(pfo_pkg::KindNormal, nn, 1'b0, 1'b0);
      push(pfo_pkg::KindCentre, ctr, 1'b1, sat);
    endfunction

    task check_result(input pfo_pkg::out_item_t got);
      pfo_pkg::out_item_t e;
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      e = expected_frames.pop_front();
      if (got.result_kind !== e.result_kind)
        report_mismatch($sformatf("kind %0d want %0d", got.result_kind, e.result_kind));
      if (got.comp_x !== e.comp_x)
        report_mismatch($sformatf("kind %0d x %h want %h", e.result_kind, got.comp_x, e.comp_x));
      if (got.comp_y !== e.comp_y)
        report_mismatch($sformatf("kind %0d y %h want %h", e.result_kind, got.comp_y, e.comp_y));
      if (got.comp_z !== e.comp_z)
        report_mismatch($sformatf("kind %0d z %h want %h", e.result_kind, got.comp_z, e.comp_z));
      if (got.last !== e.last)
        report_mismatch($sformatf("kind %0d last %b want %b", e.result_kind, got.last, e.last));
      if (got.degenerate !== e.degenerate)
        report_mismatch($sformatf("kind %0d degenerate %b want %b", e.result_kind,
                                  got.degenerate, e.degenerate));
    endtask

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  pfo_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  pfo_pkg::out_item_t out_data_o;

  frame_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  plane_frame_and_offset dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic send_plane(input pfo_pkg::in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_plane(it);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($signed(16'($urandom())));
      2: return 32'($signed(4'($urandom())));
      3: return 32'd0;
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  function automatic pfo_pkg::in_item_t rand_plane();
    pfo_pkg::in_item_t it;
    it.point_x  = ($urandom_range(1)) ? $urandom() : rand_comp();
    it.point_y  = ($urandom_range(1)) ? $urandom() : rand_comp();
    it.point_z  = ($urandom_range(1)) ? $urandom() : rand_comp();
    it.normal_x = rand_comp();
    it.normal_y = rand_comp();
    it.normal_z = rand_comp();
    // push some normals toward the seed switch
    if ($urandom_range(4) == 0) begin
      it.normal_x = ($urandom_range(1) ? 32'sd1 : -32'sd1) * 32'sd65536;
      it.normal_y = 32'($signed(15'($urandom())));
      it.normal_z = 32'($signed(15'($urandom())));
    end
    if ($urandom_range(19) == 0) begin
      it.normal_x = '0;
      it.normal_y = '0;
      it.normal_z = '0;
    end
    it.reach = ($urandom_range(1)) ? 31'($urandom()) : 31'($urandom_range(1 << 20));
    return it;
  endfunction

  function automatic pfo_pkg::in_item_t mk(input logic [31:0] px, py, pz, nx, ny, nz,
                                           input logic [30:0] r);
    pfo_pkg::in_item_t it;
    it = '{px, py, pz, nx, ny, nz, r};
    return it;
  endfunction

  // receiver
  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    pfo_pkg::in_item_t dir[$];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir = {dir, mk(0, 0, 0, 0, 0, 0, 31'h7fffffff)};
    dir = {dir, mk(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0)};
    dir = {dir, mk(0, 0, 0, 32'h00010000, 0, 0, 31'h00010000)};
    dir = {dir, mk(0, 0, 0, 32'hffff0000, 0, 0, 31'h00010000)};
    dir = {dir, mk(0, 0, 0, 0, 32'h00010000, 0, 31'h00010000)};
    dir = {dir, mk(0, 0, 0, 0, 0, 32'hffff0000, 31'h00010000)};
    dir = {dir, mk(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff)};
    dir = {dir, mk(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0)};
    dir = {dir, mk(0, 0, 0, 1, 0, 0, 5)};
    dir = {dir, mk(0, 0, 0, 0, 0, 1, 5)};
    dir = {dir, mk(0, 0, 0, 32'hffffffff, 1, 1, 5)};
    // just below the 0.9 seed threshold
    dir = {dir, mk(0, 0, 0, 32'd90000, 32'd43589, 0, 31'd65536)};
    dir = {dir, mk(0, 0, 0, 32'd90000, 32'd43600, 0, 31'd65536)};
    dir = {dir, mk(0, 0, 0, -32'sd90000, 0, 32'd43589, 31'd65536)};
    // centre saturation both ways
    dir = {dir, mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h00010000,
                   32'h00010000, 32'h00010000, 31'h7fffffff)};
    dir = {dir, mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffff0000,
                   32'hffff0000, 32'hffff0000, 31'h7fffffff)};
    dir = {dir, mk(32'h7fffffff, 32'h80000000, 32'h12345678, 32'h00030000,
                   32'hfffc0000, 32'h00050000, 31'h40000000)};
    dir = {dir, mk(32'hdeadbeef, 32'h01234567, 32'h89abcdef, 32'h00000003,
                   32'h00000007, 32'hfffffffe, 31'h00000001)};
    foreach (dir[i]) send_plane(dir[i]);

    for (int n = 0; n < 330; n++) begin
      if (n == 80 || n == 160 || n == 240) begin
        // drain fully between idling phases
        in_valid_i <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      case (n / 80)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (n == 20) hold_req = 1'b1;
      send_plane(rand_plane());
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_plane_frame_and_offset: clean");
    end else begin
      $display("tb_plane_frame_and_offset: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_plane_frame_and_offset: errors");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/pfo_pkg.sv
rtl/core/pfo_front.sv
rtl/core/pfo_queue.sv
rtl/core/pfo_back.sv
rtl/core/plane_frame_and_offset.sv
bench/tb_plane_frame_and_offset.sv
